/* hw/rtl/scharr_pkg.sv */
// shared constants, codes and stage types of the scharr gradient filter
`timescale 1ns / 1ps
`default_nettype none

package scharr_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int MAX_HEIGHT    = 4096;

  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 12;
  localparam int SUM_W      = 13;
  localparam int DIFF_W     = 9;
  localparam int GRAD_W     = 13;
  localparam int CFG_DATA_W = 13;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 12'd640;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // position of one pixel within the frame, as the result sequencer needs it
  typedef struct packed {
    logic single_row;
    logic run0;
    logic run1;
    logic wd1;
    logic x_is0;
    logic x_is1;
    logic x_last;
  } pos_flags_t;

  // vertical column values handed to the window stage
  typedef struct packed {
    pos_flags_t        pos;
    logic [SUM_W-1:0]  smooth0;
    logic [DIFF_W-1:0] diff0;
    logic [SUM_W-1:0]  smooth1;
  } col_req_t;

endpackage

`default_nettype wire

/* hw/rtl/scharr_line_store.sv */
// two row buffers packed in one synchronous memory, with write-to-read forwarding
`timescale 1ns / 1ps
`default_nettype none

module scharr_line_store #(
  parameter int DEPTH = scharr_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]       rd_addr,
  output logic      [2*scharr_pkg::PIX_W-1:0] rd_data,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  wire logic [2*scharr_pkg::PIX_W-1:0] wr_data
);
  import scharr_pkg::*;

  // each entry holds {older row, newer row}
  logic [2*PIX_W-1:0] mem [DEPTH];
  logic [2*PIX_W-1:0] mem_q;
  logic [2*PIX_W-1:0] fwd_data;
  logic               fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      // a write to the same entry at the read edge is not yet in mem_q
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

`default_nettype wire

/* hw/rtl/scharr_window_emit.sv */
// three-column windows, result sequencer and output register
`timescale 1ns / 1ps
`default_nettype none

module scharr_window_emit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            clear,
  input  wire logic                            col_valid,
  output logic                                 col_ready,
  input  wire scharr_pkg::col_req_t            col,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [scharr_pkg::GRAD_W-1:0] grad_x,
  output logic signed [scharr_pkg::GRAD_W-1:0] grad_y,
  output logic                                 frame_end
);
  import scharr_pkg::*;

  logic [SUM_W-1:0]  sw0 [3];
  logic [SUM_W-1:0]  sw1 [3];
  logic [DIFF_W-1:0] dw0 [3];

  logic       busy;
  pos_flags_t pos;
  logic       part;
  logic       win;

  logic [1:0] per_win;
  logic       any_result;
  logic       last_part;
  logic       last_win;
  logic       out_free;
  logic       emit;
  logic       done;
  logic       load;

  logic [SUM_W-1:0]  sa, sb, sc, sl, sr;
  logic [DIFF_W-1:0] da, db, dc, dl, dm, dr;
  logic [GRAD_W-1:0] dl_e, dm_e, dr_e, dsum;
  logic [GRAD_W-1:0] gx_v, gy_v;
  logic              fe_v;

  // results per window: one for a one-column frame, else none at the first column, two at the last
  assign per_win    = pos.wd1 ? 2'd1 : (pos.x_is0 ? 2'd0 : (pos.x_last ? 2'd2 : 2'd1));
  assign any_result = pos.run0 && (per_win != 2'd0);
  assign last_part  = (per_win != 2'd2) || part;
  assign last_win   = !pos.run1 || win;
  assign out_free   = !out_valid || out_ready;
  assign emit       = busy && any_result && out_free;
  assign done       = busy && (!any_result || (emit && last_part && last_win));
  assign col_ready  = !busy || done;
  assign load       = col_valid && col_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos  <= col.pos;
      part <= 1'b0;
      win  <= 1'b0;
    end else if (emit) begin
      if (last_part) begin
        part <= 1'b0;
        win  <= 1'b1;
      end else begin
        part <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < 3; i++) begin
        sw0[i] <= '0;
        sw1[i] <= '0;
        dw0[i] <= '0;
      end
    end else if (load) begin
      if (col.pos.run0) begin
        sw0[0] <= sw0[1];
        sw0[1] <= sw0[2];
        sw0[2] <= col.smooth0;
        dw0[0] <= dw0[1];
        dw0[1] <= dw0[2];
        dw0[2] <= col.diff0;
      end
      if (col.pos.run1) begin
        sw1[0] <= sw1[1];
        sw1[1] <= sw1[2];
        sw1[2] <= col.smooth1;
      end
    end
  end

  always_comb begin
    if (win) begin
      // the last-row window carries no vertical difference
      sa = sw1[0];
      sb = sw1[1];
      sc = sw1[2];
      da = '0;
      db = '0;
      dc = '0;
    end else begin
      sa = sw0[0];
      sb = sw0[1];
      sc = sw0[2];
      da = dw0[0];
      db = dw0[1];
      dc = dw0[2];
    end

    if (pos.wd1) begin
      sl   = sc;
      sr   = sc;
      dl   = dc;
      dm   = dc;
      dr   = dc;
      fe_v = win || pos.single_row;
    end else if (!part) begin
      // second column mirrors onto the column to its right
      sl   = pos.x_is1 ? sc : sa;
      sr   = sc;
      dl   = pos.x_is1 ? dc : da;
      dm   = db;
      dr   = dc;
      fe_v = 1'b0;
    end else begin
      // flush of the last column, right side mirrored
      sl   = sb;
      sr   = sb;
      dl   = db;
      dm   = dc;
      dr   = db;
      fe_v = win || pos.single_row;
    end

    dl_e = {{(GRAD_W-DIFF_W){dl[DIFF_W-1]}}, dl};
    dm_e = {{(GRAD_W-DIFF_W){dm[DIFF_W-1]}}, dm};
    dr_e = {{(GRAD_W-DIFF_W){dr[DIFF_W-1]}}, dr};
    dsum = dl_e + dr_e;
    gx_v = GRAD_W'(sr) - GRAD_W'(sl);
    gy_v = (dsum << 1) + dsum + (dm_e << 3) + (dm_e << 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      grad_x    <= gx_v;
      grad_y    <= gy_v;
      frame_end <= fe_v;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/scharr_gradient_filter_unit.sv */
// scharr gradient filter top: configuration, raster counters, column stage
// an accepted pixel passes the stage-1 register; its first result is registered at the
// output once that is free; one pixel per cycle while the output accepts, but a pixel
// emitting several results holds the sequencer until all are out (two at a row end, up to
// four at the end of the last row), one result per cycle; reset: width 640, height 480,
// counters, windows zero; row buffers not cleared, always written before read in a frame
`timescale 1ns / 1ps
`default_nettype none

module scharr_gradient_filter_unit #(
  parameter int MAX_WIDTH = scharr_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire scharr_pkg::cfg_reg_t                cfg_index,
  input  wire logic [scharr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [scharr_pkg::PIX_W-1:0]        pixel,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [scharr_pkg::GRAD_W-1:0]     grad_x,
  output logic signed [scharr_pkg::GRAD_W-1:0]     grad_y,
  output logic                                     frame_end
);
  import scharr_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WCW  = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WCW > WIDTH_W) ? WCW : WIDTH_W;

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [CW-1:0]       col_cnt;
  logic [ROW_W-1:0]    row_cnt;

  logic [CMPW-1:0]     width_ext;
  logic [CMPW-1:0]     wd_eff;
  logic [HEIGHT_W-1:0] ht_eff;
  logic                col_last;
  logic                row_last;
  logic                row_nz;
  logic                accept;
  pos_flags_t          pos_now;

  logic                s1_valid;
  logic [PIX_W-1:0]    s1_pixel;
  logic [CW-1:0]       s1_addr;
  pos_flags_t          s1_pos;
  logic                s1_first;
  logic                s1_fire;

  logic [2*PIX_W-1:0]  rd_data;
  logic [PIX_W-1:0]    above;
  logic [PIX_W-1:0]    up;
  logic [PIX_W:0]      vsum;
  logic [SUM_W-1:0]    smooth0;
  logic [SUM_W-1:0]    smooth1;
  logic [DIFF_W-1:0]   diff0;

  col_req_t            col;
  logic                col_ready;

  // out-of-range sizes clamp to the nearest legal value
  always_comb begin
    width_ext = CMPW'(image_width);
    if (width_ext == '0) begin
      wd_eff = CMPW'(1);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      wd_eff = CMPW'(MAX_WIDTH);
    end else begin
      wd_eff = width_ext;
    end
    if (image_height == '0) begin
      ht_eff = HEIGHT_W'(1);
    end else if (image_height > HEIGHT_W'(MAX_HEIGHT)) begin
      ht_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      ht_eff = image_height;
    end
  end

  assign col_last = (CMPW'(col_cnt) + CMPW'(1)) == wd_eff;
  assign row_last = (HEIGHT_W'(row_cnt) + HEIGHT_W'(1)) == ht_eff;
  assign row_nz   = row_cnt != '0;

  always_comb begin
    pos_now.single_row = ht_eff == HEIGHT_W'(1);
    pos_now.run0       = pos_now.single_row || row_nz;
    pos_now.run1       = !pos_now.single_row && row_nz && row_last;
    pos_now.wd1        = wd_eff == CMPW'(1);
    pos_now.x_is0      = col_cnt == '0;
    pos_now.x_is1      = col_cnt == CW'(1);
    pos_now.x_last     = col_last;
  end

  assign s1_fire  = s1_valid && col_ready;
  assign in_ready = !s1_valid || col_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      col_cnt      <= '0;
      row_cnt      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_cnt <= '0;
        row_cnt <= row_last ? '0 : row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel;
      s1_addr  <= col_cnt;
      s1_pos   <= pos_now;
      s1_first <= row_cnt == ROW_W'(1);
    end
  end

  scharr_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cnt),
    .rd_data (rd_data),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr),
    .wr_data ({rd_data[PIX_W-1:0], s1_pixel})
  );

  // vertical smooth and difference of the column ending at this pixel
  always_comb begin
    above = rd_data[PIX_W-1:0];
    // the second row mirrors the row above onto the current one
    up    = s1_first ? s1_pixel : rd_data[2*PIX_W-1:PIX_W];
    vsum  = {1'b0, up} + {1'b0, s1_pixel};
    if (s1_pos.single_row) begin
      smooth0 = SUM_W'(s1_pixel) << 4;
      diff0   = '0;
    end else begin
      smooth0 = (SUM_W'(vsum) << 1) + SUM_W'(vsum) + (SUM_W'(above) << 3)
              + (SUM_W'(above) << 1);
      diff0   = {1'b0, s1_pixel} - {1'b0, up};
    end
    smooth1 = (SUM_W'(above) << 2) + (SUM_W'(above) << 1) + (SUM_W'(s1_pixel) << 3)
            + (SUM_W'(s1_pixel) << 1);
  end

  assign col.pos     = s1_pos;
  assign col.smooth0 = smooth0;
  assign col.diff0   = diff0;
  assign col.smooth1 = smooth1;

  scharr_window_emit u_window_emit (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_we),
    .col_valid (s1_valid),
    .col_ready (col_ready),
    .col       (col),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .grad_x    (grad_x),
    .grad_y    (grad_y),
    .frame_end (frame_end)
  );

endmodule

`default_nettype wire

/* verif/scharr_gradient_filter_unit_tb.sv */
// self-checking testbench for the scharr gradient filter unit
`timescale 1ns / 1ps

module scharr_gradient_filter_unit_tb;
  import scharr_pkg::*;

  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 400;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     fe;
  } grad_t;

  class scharr_gradient_tracker;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [PIX_W-1:0]    older_row[MAX_W];
    logic [PIX_W-1:0]    newer_row[MAX_W];
    int                  smooth_win[2][3];
    int                  diff_win[2][3];
    int                  col;
    int                  row;
    grad_t               pending_grads[$];
    int                  mismatches;

    function new();
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      for (int w = 0; w < 2; w++) begin
        for (int k = 0; k < 3; k++) begin
          smooth_win[w][k] = 0;
          diff_win[w][k]   = 0;
        end
      end
      col = 0;
      row = 0;
    endfunction

    function void write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = value[WIDTH_W-1:0];
      end else begin
        height_reg = value;
      end
      restart();
    endfunction

    function void push_grad(int gx, int gy, bit fe);
      grad_t g;
      g.gx = gx[GRAD_W-1:0];
      g.gy = gy[GRAD_W-1:0];
      g.fe = fe;
      pending_grads.push_back(g);
    endfunction

    // shift one vertical column into window w and queue what it completes
    function void feed_column(int w, int s, int d, int x, int wd, bit last_row);
      int sl;
      int dl;
      smooth_win[w][0] = smooth_win[w][1];
      smooth_win[w][1] = smooth_win[w][2];
      smooth_win[w][2] = s;
      diff_win[w][0]   = diff_win[w][1];
      diff_win[w][1]   = diff_win[w][2];
      diff_win[w][2]   = d;
      if (wd == 1) begin
        push_grad(0, 16 * d, last_row);
        return;
      end
      if (x == 0) return;
      // left neighbor of column 1 reflects to column 2
      sl = (x == 1) ? smooth_win[w][2] : smooth_win[w][0];
      dl = (x == 1) ? diff_win[w][2] : diff_win[w][0];
      push_grad(smooth_win[w][2] - sl, 3 * (dl + diff_win[w][2]) + 10 * diff_win[w][1], 1'b0);
      if (x == wd - 1) begin
        push_grad(0, 6 * diff_win[w][1] + 10 * diff_win[w][2], last_row);
      end
    endfunction

    function void note_pixel(logic [PIX_W-1:0] p);
      int wd;
      int ht;
      int x;
      int y;
      int pv;
      int above;
      int up;
      wd = width_reg;
      ht = height_reg;
      x  = col;
      y  = row;
      pv = p;
      if (wd == 0) wd = 1;
      if (wd > MAX_W) wd = MAX_W;
      if (ht == 0) ht = 1;
      if (ht > MAX_HEIGHT) ht = MAX_HEIGHT;
      if (x >= wd) x = 0;
      if (y >= ht) y = 0;
      if (ht == 1) begin
        feed_column(0, 16 * pv, 0, x, wd, 1'b1);
      end else if (y > 0) begin
        above = newer_row[x];
        up    = (y == 1) ? pv : int'(older_row[x]);
        feed_column(0, 3 * (up + pv) + 10 * above, pv - up, x, wd, 1'b0);
        // last row also flushes its own results, mirrored from the row above
        if (y == ht - 1) feed_column(1, 6 * above + 10 * pv, 0, x, wd, 1'b1);
      end
      older_row[x] = newer_row[x];
      newer_row[x] = p;
      x++;
      if (x >= wd) begin
        x = 0;
        y++;
        if (y >= ht) y = 0;
      end
      col = x;
      row = y;
    endfunction

    function void check_grad(logic signed [GRAD_W-1:0] gx, logic signed [GRAD_W-1:0] gy,
                             logic fe);
      grad_t exp_g;
      if (pending_grads.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: gx=%0d gy=%0d frame_end=%0b", gx, gy, fe);
        return;
      end
      exp_g = pending_grads.pop_front();
      if (gx !== exp_g.gx || gy !== exp_g.gy || fe !== exp_g.fe) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"result mismatch: expected gx=%0d gy=%0d frame_end=%0b, ",
                    "got gx=%0d gy=%0d frame_end=%0b"},
                   exp_g.gx, exp_g.gy, exp_g.fe, gx, gy, fe);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  cfg_reg_t                  cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [PIX_W-1:0]          pixel;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [GRAD_W-1:0]  grad_x;
  logic signed [GRAD_W-1:0]  grad_y;
  logic                      frame_end;

  bit src_gaps_on     = 1'b1;
  bit sink_gaps_on    = 1'b1;
  bit hold_output_req = 1'b0;
  int stall_left      = 0;

  scharr_gradient_tracker tracker = new();

  scharr_gradient_filter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .grad_x    (grad_x),
    .grad_y    (grad_y),
    .frame_end (frame_end)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_pixel(pixel);
      if (out_valid && out_ready) tracker.check_grad(grad_x, grad_y, frame_end);
    end
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_output_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (sink_gaps_on && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int n;
    if (src_gaps_on && $urandom_range(0, 99) < 30) begin
      n = pick_gap();
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid = 1'b1;
    pixel    = p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_pixels(input logic [PIX_W-1:0] q[$], input int hold_at);
    for (int i = 0; i < q.size(); i++) begin
      if (i == hold_at) hold_output_req = 1'b1;
      send_pixel(q[i]);
    end
    in_valid = 1'b0;
  endtask

  task automatic fill_pixels(ref logic [PIX_W-1:0] q[$], input int count, input bit extremes);
    q.delete();
    for (int i = 0; i < count; i++) begin
      if (extremes) q.push_back($urandom_range(0, 1) ? 8'd255 : 8'd0);
      else q.push_back(PIX_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    tracker.write_register(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // registers change only once all results are out and the pipe is quiet
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    while (tracker.pending_grads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    write_cfg(REG_IMAGE_WIDTH, w);
    write_cfg(REG_IMAGE_HEIGHT, h);
  endtask

  initial begin
    #(50_000_000);
    $display("** scharr_gradient_filter_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [PIX_W-1:0] px[$];
    int random_items;
    int w;
    int h;
    int frame_px;
    int count;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_IMAGE_WIDTH;
    cfg_data     = '0;
    in_valid     = 1'b0;
    pixel        = '0;
    random_items = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset geometry: part of the first row, which gives no results yet
    fill_pixels(px, 24, 1'b0);
    send_pixels(px, -1);

    // single pixel frames
    set_geometry(13'd1, 13'd1);
    px = '{8'd0, 8'd255, 8'd128};
    send_pixels(px, -1);
    // full-scale steps in both directions, corners and edges
    set_geometry(13'd3, 13'd3);
    px = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255, 8'd255};
    send_pixels(px, -1);
    set_geometry(13'd3, 13'd3);
    px = '{8'd255, 8'd255, 8'd0, 8'd255, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0};
    send_pixels(px, -1);
    // single row
    set_geometry(13'd2, 13'd1);
    px = '{8'd255, 8'd0, 8'd0, 8'd255};
    send_pixels(px, -1);

    // small random geometries, whole frames mostly, some cut short by a rewrite
    while (random_items < 260) begin
      w = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 99) < 10) w = $urandom_range(9, 40);
      h = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 5);
      frame_px = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      if ($urandom_range(0, 99) < 60) count = frame_px * $urandom_range(1, 2);
      else count = $urandom_range(1, 2 * frame_px);
      if (random_items + count > 280) count = 280 - random_items;
      src_gaps_on  = ($urandom_range(0, 3) != 0);
      sink_gaps_on = ($urandom_range(0, 3) != 0);
      set_geometry(CFG_DATA_W'(w), CFG_DATA_W'(h));
      fill_pixels(px, count, $urandom_range(0, 99) < 20);
      send_pixels(px, -1);
      random_items += count;
    end

    // wider rows; the output is held off midway so the input backs up
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b1;
    set_geometry(13'd24, 13'd3);
    fill_pixels(px, 72, 1'b0);
    send_pixels(px, 30);

    // width beyond the row buffers clamps, single row
    src_gaps_on = 1'b1;
    set_geometry(13'h1FFF, 13'd1);
    fill_pixels(px, 24, 1'b0);
    send_pixels(px, -1);

    // zero width and a height beyond the limit: one column
    set_geometry(13'd0, 13'h1FFF);
    fill_pixels(px, 20, 1'b0);
    send_pixels(px, -1);

    while (tracker.pending_grads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_grads.size() == 0) begin
      $display("** scharr_gradient_filter_unit: PASSED **");
    end else begin
      $display("** scharr_gradient_filter_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* scharr_gradient_filter_unit.f */
hw/rtl/scharr_pkg.sv
hw/rtl/scharr_line_store.sv
hw/rtl/scharr_window_emit.sv
hw/rtl/scharr_gradient_filter_unit.sv
verif/scharr_gradient_filter_unit_tb.sv
